/* rtl/core/lldq_pkg.sv */
// ----------------------------------------------------------------------------
// lldq_pkg
// Shared types, codes and constants of the linked list deque engine.
// ----------------------------------------------------------------------------
package lldq_pkg;

  localparam int unsigned CAPACITY_DEF = 128;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned COUNT_OUT_W  = 8;
  localparam int unsigned GRP_W        = 8;   // free map bits checked per scan cycle

  typedef enum logic [2:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_ERASE      = 3'd4,
    MODE_CLEAR      = 3'd5,
    MODE_SORT       = 3'd6,
    MODE_PEEK       = 3'd7
  } mode_e;

  typedef struct packed {
    mode_e                     mode;
    logic signed [VALUE_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic                      ok;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] back_value;
    logic [COUNT_OUT_W-1:0]    entry_count;
    logic                      is_empty;
  } out_item_t;

  // datapath micro-operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_ADD,
    OP_LINK,
    OP_SCAN,
    OP_READ,
    OP_ERASE_STEP,
    OP_DROP,
    OP_FIX,
    OP_CLEAR,
    OP_SRD_NEXT,
    OP_SRD_VAL,
    OP_BUBBLE,
    OP_PASS_END
  } dp_op_e;

  typedef struct packed {
    dp_op_e                    op;
    mode_e                     mode;
    logic signed [VALUE_W-1:0] value;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic sort_small;   // fewer than two entries
    logic match;
    logic walk_last;
    logic scan_done;
    logic sort_last;
    logic swapped;
  } dp_status_t;

endpackage

/* rtl/core/lldq_stream_if.sv */
// ----------------------------------------------------------------------------
// lldq_stream_if
// Valid/ready channel carrying one payload item per beat.
// ----------------------------------------------------------------------------
interface lldq_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/lldq_ram.sv */
// ----------------------------------------------------------------------------
// lldq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module lldq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/core/lldq_dp.sv */
// ----------------------------------------------------------------------------
// lldq_dp
// List datapath: node stores, head/tail/count, free map and walk registers.
// ----------------------------------------------------------------------------
module lldq_dp #(
  parameter int unsigned CAPACITY = lldq_pkg::CAPACITY_DEF,
  localparam int unsigned SlotW = $clog2(CAPACITY + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lldq_pkg::dp_cmd_t                   cmd_i,
  output lldq_pkg::dp_status_t                status_o,
  output logic signed [lldq_pkg::VALUE_W-1:0] head_val_o,
  output logic signed [lldq_pkg::VALUE_W-1:0] tail_val_o,
  output logic [SlotW-1:0]                    count_o
);
  import lldq_pkg::*;

  localparam int unsigned AddrW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned GrpN    = (CAPACITY + GRP_W - 1) / GRP_W;
  localparam int unsigned GrpIdxW = (GrpN > 1) ? $clog2(GrpN) : 1;
  localparam int unsigned FreeW   = GrpN * GRP_W;
  localparam logic [FreeW-1:0] FreeInit = {FreeW{1'b1}} >> (FreeW - CAPACITY);
  localparam logic [SlotW-1:0] NullSlot = SlotW'(CAPACITY);

  logic [SlotW-1:0]          head_q, tail_q, cur_q, nxt_q, alloc_q, count_q, step_q;
  logic                      alloc_vld_q, swapped_q, fix_head_q, fix_tail_q;
  logic [GrpIdxW-1:0]        scan_q;
  logic [FreeW-1:0]          free_q;
  mode_e                     mode_q;
  logic signed [VALUE_W-1:0] value_q, carry_q, head_val_q, tail_val_q;

  logic               val_we, val_re, prev_we, prev_re, next_we, next_re;
  logic [AddrW-1:0]   val_waddr, val_raddr, prev_waddr, prev_raddr, next_waddr, next_raddr;
  logic [VALUE_W-1:0] val_wdata, val_rdata;
  logic [SlotW-1:0]   prev_wdata, prev_rdata, next_wdata, next_rdata;

  lldq_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i, .we_i(val_we), .waddr_i(val_waddr), .wdata_i(val_wdata),
    .re_i(val_re), .raddr_i(val_raddr), .rdata_o(val_rdata)
  );
  lldq_ram #(.WIDTH(SlotW), .DEPTH(CAPACITY)) u_prev_ram (
    .clk_i, .we_i(prev_we), .waddr_i(prev_waddr), .wdata_i(prev_wdata),
    .re_i(prev_re), .raddr_i(prev_raddr), .rdata_o(prev_rdata)
  );
  lldq_ram #(.WIDTH(SlotW), .DEPTH(CAPACITY)) u_next_ram (
    .clk_i, .we_i(next_we), .waddr_i(next_waddr), .wdata_i(next_wdata),
    .re_i(next_re), .raddr_i(next_raddr), .rdata_o(next_rdata)
  );

  logic                      empty, is_back, was_head, was_tail, grp_any;
  logic [GRP_W-1:0]          grp_bits;
  logic [2:0]                ffs;
  logic signed [VALUE_W-1:0] rd_val, lo_val, hi_val;

  always_comb begin
    empty    = (count_q == '0);
    is_back  = (mode_q == MODE_PUSH_BACK);
    was_head = (head_q == cur_q);
    was_tail = (tail_q == cur_q);
    grp_bits = free_q[{scan_q, 3'b000} +: GRP_W];
    grp_any  = |grp_bits;
    ffs      = '0;
    for (int i = GRP_W - 1; i >= 0; i--) begin
      if (grp_bits[i]) ffs = 3'(i);
    end
    rd_val = val_rdata;
    lo_val = (carry_q > rd_val) ? rd_val : carry_q;
    hi_val = (carry_q > rd_val) ? carry_q : rd_val;
  end

  always_comb begin
    status_o.empty      = empty;
    status_o.full       = (count_q == NullSlot);
    status_o.sort_small = (count_q < SlotW'(2));
    status_o.match      = (rd_val == value_q);
    status_o.walk_last  = ((step_q + SlotW'(1)) >= count_q) || (next_rdata >= NullSlot);
    status_o.sort_last  = ((step_q + SlotW'(2)) == count_q);
    status_o.scan_done  = grp_any || (scan_q == GrpIdxW'(GrpN - 1));
    status_o.swapped    = swapped_q;
  end

  // store accesses
  always_comb begin
    val_we  = 1'b0; val_waddr  = cur_q[AddrW-1:0]; val_wdata  = value_q;
    prev_we = 1'b0; prev_waddr = cur_q[AddrW-1:0]; prev_wdata = NullSlot;
    next_we = 1'b0; next_waddr = cur_q[AddrW-1:0]; next_wdata = NullSlot;
    val_re  = 1'b0; val_raddr  = cur_q[AddrW-1:0];
    prev_re = 1'b0; prev_raddr = cur_q[AddrW-1:0];
    next_re = 1'b0; next_raddr = cur_q[AddrW-1:0];
    unique case (cmd_i.op)
      OP_ADD: begin
        val_we     = 1'b1;
        val_waddr  = alloc_q[AddrW-1:0];
        prev_we    = 1'b1;
        prev_waddr = alloc_q[AddrW-1:0];
        prev_wdata = (is_back && !empty) ? tail_q : NullSlot;
        next_we    = 1'b1;
        next_waddr = alloc_q[AddrW-1:0];
        next_wdata = (!is_back && !empty) ? head_q : NullSlot;
      end
      OP_LINK: begin
        if (!empty && is_back) begin
          next_we    = 1'b1;
          next_waddr = tail_q[AddrW-1:0];
          next_wdata = cur_q;
        end
        if (!empty && !is_back) begin
          prev_we    = 1'b1;
          prev_waddr = head_q[AddrW-1:0];
          prev_wdata = cur_q;
        end
      end
      OP_READ: begin
        val_re  = 1'b1;
        prev_re = 1'b1;
        next_re = 1'b1;
      end
      OP_DROP: begin
        if (!was_head && prev_rdata < NullSlot) begin
          next_we    = 1'b1;
          next_waddr = prev_rdata[AddrW-1:0];
          next_wdata = next_rdata;
        end
        if (!was_tail && next_rdata < NullSlot) begin
          prev_we    = 1'b1;
          prev_waddr = next_rdata[AddrW-1:0];
          prev_wdata = prev_rdata;
        end
        val_re    = 1'b1;
        val_raddr = was_head ? next_rdata[AddrW-1:0] : prev_rdata[AddrW-1:0];
      end
      OP_SRD_NEXT: next_re = 1'b1;
      OP_SRD_VAL: begin
        val_re    = 1'b1;
        val_raddr = next_rdata[AddrW-1:0];
      end
      OP_BUBBLE: begin
        val_we    = 1'b1;
        val_wdata = lo_val;
      end
      OP_PASS_END: begin
        val_we    = 1'b1;
        val_wdata = carry_q;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= NullSlot;
      tail_q      <= NullSlot;
      count_q     <= '0;
      free_q      <= FreeInit;
      alloc_q     <= '0;
      alloc_vld_q <= 1'b1;
      scan_q      <= '0;
      cur_q       <= NullSlot;
      nxt_q       <= NullSlot;
      step_q      <= '0;
      swapped_q   <= 1'b0;
      fix_head_q  <= 1'b0;
      fix_tail_q  <= 1'b0;
      mode_q      <= MODE_PEEK;
    end else begin
      unique case (cmd_i.op)
        OP_START: begin
          mode_q    <= cmd_i.mode;
          cur_q     <= (cmd_i.mode == MODE_POP_BACK) ? tail_q : head_q;
          step_q    <= '0;
          swapped_q <= 1'b0;
        end
        OP_ADD: begin
          cur_q                     <= alloc_q;
          free_q[alloc_q[AddrW-1:0]] <= 1'b0;
        end
        OP_LINK: begin
          if (is_back || empty) tail_q <= cur_q;
          if (!is_back || empty) head_q <= cur_q;
          count_q <= count_q + SlotW'(1);
          scan_q  <= GrpIdxW'(cur_q >> 3);
        end
        OP_SCAN: begin
          if (grp_any) begin
            alloc_q     <= SlotW'({scan_q, ffs});
            alloc_vld_q <= 1'b1;
          end else if (scan_q == GrpIdxW'(GrpN - 1)) begin
            alloc_vld_q <= 1'b0;
          end else begin
            scan_q <= scan_q + GrpIdxW'(1);
          end
        end
        OP_ERASE_STEP: begin
          if (rd_val != value_q) begin
            cur_q  <= next_rdata;
            step_q <= step_q + SlotW'(1);
          end
        end
        OP_DROP: begin
          count_q                  <= count_q - SlotW'(1);
          free_q[cur_q[AddrW-1:0]] <= 1'b1;
          if (!alloc_vld_q || cur_q < alloc_q) begin
            alloc_q     <= cur_q;
            alloc_vld_q <= 1'b1;
          end
          if (count_q == SlotW'(1)) begin
            head_q <= NullSlot;
            tail_q <= NullSlot;
          end else begin
            if (was_head) head_q <= next_rdata;
            if (was_tail) tail_q <= prev_rdata;
          end
          fix_head_q <= was_head;
          fix_tail_q <= was_tail;
        end
        OP_CLEAR: begin
          head_q      <= NullSlot;
          tail_q      <= NullSlot;
          count_q     <= '0;
          free_q      <= FreeInit;
          alloc_q     <= '0;
          alloc_vld_q <= 1'b1;
        end
        OP_SRD_VAL: nxt_q <= next_rdata;
        OP_BUBBLE: begin
          if (carry_q > rd_val) swapped_q <= 1'b1;
          cur_q  <= nxt_q;
          step_q <= step_q + SlotW'(1);
        end
        OP_PASS_END: begin
          cur_q     <= head_q;
          step_q    <= '0;
          swapped_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_START: begin
        value_q <= cmd_i.value;
        carry_q <= head_val_q;
      end
      OP_LINK: begin
        if (is_back || empty) tail_val_q <= value_q;
        if (!is_back || empty) head_val_q <= value_q;
      end
      OP_FIX: begin
        if (fix_head_q) head_val_q <= rd_val;
        if (fix_tail_q) tail_val_q <= rd_val;
      end
      OP_BUBBLE: begin
        if (cur_q == head_q) head_val_q <= lo_val;
        carry_q <= hi_val;
      end
      OP_PASS_END: begin
        tail_val_q <= carry_q;
        carry_q    <= head_val_q;
      end
      default: ;
    endcase
  end

  assign head_val_o = head_val_q;
  assign tail_val_o = tail_val_q;
  assign count_o    = count_q;
endmodule

/* rtl/core/lldq_ctrl.sv */
// ----------------------------------------------------------------------------
// lldq_ctrl
// Sequencer: decodes the mode, steps the datapath, decides ok.
// ----------------------------------------------------------------------------
module lldq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  lldq_pkg::in_item_t   in_item_i,
  output logic                 in_ready_o,
  input  logic                 out_free_i,
  output logic                 out_load_o,
  output logic                 ok_o,
  input  lldq_pkg::dp_status_t status_i,
  output lldq_pkg::dp_cmd_t    cmd_o
);
  import lldq_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE     = 13'b0000000000001,
    ST_ADD      = 13'b0000000000010,
    ST_LINK     = 13'b0000000000100,
    ST_SCAN     = 13'b0000000001000,
    ST_READ     = 13'b0000000010000,
    ST_ERASE    = 13'b0000000100000,
    ST_DROP     = 13'b0000001000000,
    ST_FIX      = 13'b0000010000000,
    ST_CLEAR    = 13'b0000100000000,
    ST_SRD_NEXT = 13'b0001000000000,
    ST_SRD_VAL  = 13'b0010000000000,
    ST_BUBBLE   = 13'b0100000000000,
    ST_PASS_END = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d, ok_q, ok_d, erase_q, erase_d;

  always_comb begin
    state_d    = state_q;
    done_d     = done_q;
    ok_d       = ok_q;
    erase_d    = erase_q;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    cmd_o.op    = OP_NONE;
    cmd_o.mode  = in_item_i.mode;
    cmd_o.value = in_item_i.item_value;

    if (done_q) begin
      // result waits for the output register
      if (out_free_i) begin
        out_load_o = 1'b1;
        done_d     = 1'b0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.op = OP_START;
            ok_d     = 1'b1;
            erase_d  = (in_item_i.mode == MODE_ERASE);
            unique case (in_item_i.mode)
              MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
                if (status_i.full) begin
                  ok_d   = 1'b0;
                  done_d = 1'b1;
                end else begin
                  state_d = ST_ADD;
                end
              end
              MODE_POP_BACK, MODE_POP_FRONT, MODE_ERASE: begin
                if (status_i.empty) begin
                  ok_d   = 1'b0;
                  done_d = 1'b1;
                end else begin
                  state_d = ST_READ;
                end
              end
              MODE_CLEAR: state_d = ST_CLEAR;
              MODE_SORT: begin
                if (status_i.sort_small) done_d = 1'b1;
                else state_d = ST_SRD_NEXT;
              end
              MODE_PEEK: done_d = 1'b1;
            endcase
          end
        end
        ST_ADD: begin
          cmd_o.op = OP_ADD;
          state_d  = ST_LINK;
        end
        ST_LINK: begin
          cmd_o.op = OP_LINK;
          state_d  = ST_SCAN;
        end
        ST_SCAN: begin
          cmd_o.op = OP_SCAN;
          if (status_i.scan_done) begin
            state_d = ST_IDLE;
            done_d  = 1'b1;
          end
        end
        ST_READ: begin
          cmd_o.op = OP_READ;
          state_d  = erase_q ? ST_ERASE : ST_DROP;
        end
        ST_ERASE: begin
          cmd_o.op = OP_ERASE_STEP;
          priority if (status_i.match) begin
            state_d = ST_DROP;
          end else if (status_i.walk_last) begin
            ok_d    = 1'b0;
            state_d = ST_IDLE;
            done_d  = 1'b1;
          end else begin
            state_d = ST_READ;
          end
        end
        ST_DROP: begin
          cmd_o.op = OP_DROP;
          state_d  = ST_FIX;
        end
        ST_FIX: begin
          cmd_o.op = OP_FIX;
          state_d  = ST_IDLE;
          done_d   = 1'b1;
        end
        ST_CLEAR: begin
          cmd_o.op = OP_CLEAR;
          state_d  = ST_IDLE;
          done_d   = 1'b1;
        end
        ST_SRD_NEXT: begin
          cmd_o.op = OP_SRD_NEXT;
          state_d  = ST_SRD_VAL;
        end
        ST_SRD_VAL: begin
          cmd_o.op = OP_SRD_VAL;
          state_d  = ST_BUBBLE;
        end
        ST_BUBBLE: begin
          cmd_o.op = OP_BUBBLE;
          state_d  = status_i.sort_last ? ST_PASS_END : ST_SRD_NEXT;
        end
        ST_PASS_END: begin
          cmd_o.op = OP_PASS_END;
          if (status_i.swapped) begin
            state_d = ST_SRD_NEXT;
          end else begin
            state_d = ST_IDLE;
            done_d  = 1'b1;
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      ok_q    <= 1'b0;
      erase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      ok_q    <= ok_d;
      erase_q <= erase_d;
    end
  end

  assign ok_o = ok_q;
endmodule

/* rtl/core/linked_list_deque_engine.sv */
// ----------------------------------------------------------------------------
// linked_list_deque_engine
// Doubly linked list of signed 32-bit values held in a slot store.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                         | beat
//  --------+-----+-------------------------------------------------+----------
//  in_i    | in  | mode, item_value                                | one op
//  out_o   | out | ok, front_value, back_value, entry_count, empty | one result
//
//  Steps per item: peek, sort of under two entries and refused ops end at
//  accept; clear clears; pop reads, unlinks, fixes the end value; push adds,
//  links, scans the free map per 8-slot group; erase walks, unlinking a hit;
//  sort of n entries runs up to n passes of read next, read value, bubble
//  per pair, pass end. One registered read per node store per cycle.
//  One item at a time; the result register lets the next item in while
//  out_o stalls, but a finished item holds the sequencer until out_o frees.
//  Reset is immediate: the free map is flops, the node stores need no clear.
//
module linked_list_deque_engine #(
  parameter int unsigned CAPACITY = lldq_pkg::CAPACITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lldq_stream_if.sink          in_i,
  lldq_stream_if.source        out_o
);
  import lldq_pkg::*;

  localparam int unsigned SlotW = $clog2(CAPACITY + 1);

  dp_cmd_t                   cmd;
  dp_status_t                status;
  logic signed [VALUE_W-1:0] head_val, tail_val;
  logic [SlotW-1:0]          count;
  logic                      out_free, out_load, ok;
  logic                      out_vld_q;
  out_item_t                 out_q;

  lldq_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (in_i.valid),
    .in_item_i  (in_i.payload),
    .in_ready_o (in_i.ready),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .ok_o       (ok),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lldq_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i      (cmd),
    .status_o   (status),
    .head_val_o (head_val),
    .tail_val_o (tail_val),
    .count_o    (count)
  );

  // output register: frees when empty or taken this cycle
  assign out_free = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // an empty list reports zero at both ends
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.ok          <= ok;
      out_q.front_value <= (count != '0) ? head_val : '0;
      out_q.back_value  <= (count != '0) ? tail_val : '0;
      out_q.entry_count <= COUNT_OUT_W'(count);
      out_q.is_empty    <= (count == '0);
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

`ifndef SYNTHESIS
  // one item in flight: accepting closes the input next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted twice in a row");

  // a loaded result is presented next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_o.valid)
    else $error("result lost on load");

  // the list never holds more than the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= SlotW'(CAPACITY))
    else $error("entry count above capacity");

  // no result is loaded while the register still holds an untaken one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |-> !out_load)
    else $error("result overwritten");
`endif
endmodule

/* tb/sv/linked_list_deque_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_list_deque_engine_tb
// Drives deque operations into the engine and checks every result beat
// against a behavioral deque kept in the testbench, under random idling.
// ----------------------------------------------------------------------------
module linked_list_deque_engine_tb;
  import lldq_pkg::*;

  localparam int unsigned CAP = CAPACITY_DEF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Clock: 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  lldq_stream_if #(.payload_t(in_item_t))  op_if ();
  lldq_stream_if #(.payload_t(out_item_t)) res_if ();

  linked_list_deque_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (op_if.sink),
    .out_o  (res_if.source)
  );

  // Behavioral deque: values in list order, head at index 0. The slot
  // placement inside the block does not show at the outputs, so a plain
  // queue carries the whole visible state.
  logic signed [31:0] deque_vals[$];
  out_item_t          pending_results[$];
  int                 error_count = 0;
  int                 idle_cycles = 0;
  bit                 hold_off_req = 1'b0;

  function automatic out_item_t apply_op(mode_e m, logic signed [31:0] v);
    out_item_t          r;
    logic signed [31:0] key;
    int                 j;
    r.ok = 1'b1;
    case (m)
      MODE_PUSH_BACK:  if (deque_vals.size() >= CAP) r.ok = 1'b0;
                       else deque_vals.push_back(v);
      MODE_PUSH_FRONT: if (deque_vals.size() >= CAP) r.ok = 1'b0;
                       else deque_vals.push_front(v);
      MODE_POP_BACK:   if (deque_vals.size() == 0) r.ok = 1'b0;
                       else void'(deque_vals.pop_back());
      MODE_POP_FRONT:  if (deque_vals.size() == 0) r.ok = 1'b0;
                       else void'(deque_vals.pop_front());
      MODE_ERASE: begin
        r.ok = 1'b0;
        for (int i = 0; i < deque_vals.size(); i++) begin
          if (deque_vals[i] == v) begin
            deque_vals.delete(i);
            r.ok = 1'b1;
            break;
          end
        end
      end
      MODE_CLEAR: deque_vals.delete();
      MODE_SORT: begin
        // insertion sort, signed compare
        for (int i = 1; i < deque_vals.size(); i++) begin
          key = deque_vals[i];
          j = i;
          while (j > 0 && deque_vals[j-1] > key) begin
            deque_vals[j] = deque_vals[j-1];
            j--;
          end
          deque_vals[j] = key;
        end
      end
      default: ;
    endcase
    r.front_value = deque_vals.size() ? deque_vals[0] : '0;
    r.back_value  = deque_vals.size() ? deque_vals[$] : '0;
    r.entry_count = COUNT_OUT_W'(deque_vals.size());
    r.is_empty    = deque_vals.size() == 0;
    return r;
  endfunction

  // Sender: one beat per call, valid held until accepted.
  task automatic send_op(mode_e m, logic signed [31:0] v);
    op_if.payload <= '{mode: m, item_value: v};
    op_if.valid   <= 1'b1;
    @(posedge clk_i);
    while (!op_if.ready) @(posedge clk_i);
    pending_results.push_back(apply_op(m, v));
  endtask

  task automatic idle_line(int n);
    op_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Bursts of random length with random gaps between them.
  task automatic send_burst_gap();
    if ($urandom_range(0, 5) == 0) idle_line($urandom_range(1, 6));
  endtask

  task automatic wait_drained();
    op_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 4))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed(32'($urandom_range(0, 15)) - 32'd8);
      default: return $signed($urandom);
    endcase
  endfunction

  // Pick a value likely present so erases mostly hit.
  function automatic logic signed [31:0] erase_target();
    if (deque_vals.size() != 0 && $urandom_range(0, 3) != 0)
      return deque_vals[$urandom_range(0, deque_vals.size() - 1)];
    return rand_value();
  endfunction

  task automatic test_directed();
    send_op(MODE_PEEK, 0);
    send_op(MODE_POP_BACK, 0);       // empty pop
    send_op(MODE_POP_FRONT, 0);
    send_op(MODE_SORT, 0);           // sort on empty
    send_op(MODE_ERASE, 5);          // miss on empty
    send_op(MODE_PUSH_BACK, 32'sh7fff_ffff);
    send_op(MODE_PUSH_FRONT, 32'sh8000_0000);
    send_op(MODE_PUSH_BACK, -1);
    send_op(MODE_PUSH_FRONT, 0);
    send_op(MODE_PUSH_BACK, 32'sh5555_aaaa);
    send_op(MODE_SORT, 0);
    send_op(MODE_ERASE, -1);
    send_op(MODE_ERASE, 1234);       // miss
    send_op(MODE_POP_BACK, 0);
    send_op(MODE_POP_FRONT, 0);
    send_op(MODE_PEEK, 32'shffff_ffff);
    send_op(MODE_CLEAR, 0);
    send_op(MODE_PUSH_BACK, 7);
    send_op(MODE_SORT, 0);           // single entry
    send_op(MODE_POP_FRONT, 0);
    wait_drained();
  endtask

  // Fill to capacity, push into a full list, sort, erase and refill one entry, then pop from both ends and clear.
  task automatic test_full();
    for (int i = 0; i < CAP; i++) begin
      send_op($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, rand_value());
      send_burst_gap();
    end
    send_op(MODE_PUSH_BACK, 1);
    send_op(MODE_PUSH_FRONT, 2);
    send_op(MODE_SORT, 0);
    send_op(MODE_ERASE, deque_vals[CAP/2]);
    send_op(MODE_PUSH_FRONT, 3);     // refills the freed slot
    for (int i = 0; i < 40; i++) send_op(MODE_POP_BACK, 0);
    for (int i = 0; i < 20; i++) send_op(MODE_POP_FRONT, 0);
    send_op(MODE_CLEAR, 0);
    wait_drained();
  endtask

  // Receiver holds off for a long stretch while ops keep coming.
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    for (int i = 0; i < 20; i++) send_op(MODE_PUSH_BACK, rand_value());
    wait_drained();
  endtask

  task automatic test_random(int n_ops);
    mode_e m;
    int    pick;
    for (int i = 0; i < n_ops; i++) begin
      pick = $urandom_range(0, 99);
      // keep sorts rare and short; bias toward pushes so the list grows
      if (pick < 30)      m = MODE_PUSH_BACK;
      else if (pick < 55) m = MODE_PUSH_FRONT;
      else if (pick < 65) m = MODE_POP_BACK;
      else if (pick < 75) m = MODE_POP_FRONT;
      else if (pick < 87) m = MODE_ERASE;
      else if (pick < 89) m = MODE_CLEAR;
      else if (pick < 91 && deque_vals.size() < 40) m = MODE_SORT;
      else                m = MODE_PEEK;
      send_op(m, (m == MODE_ERASE) ? erase_target() : rand_value());
      send_burst_gap();
      if (i % 500 == 250) wait_drained();
    end
    wait_drained();
  endtask

  // Receiver: own stall pattern, plus one long hold-off on request.
  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (200) @(posedge clk_i);
      end
      case ($urandom_range(0, 7))
        0, 1:    res_if.ready <= 1'b0;
        default: res_if.ready <= 1'b1;
      endcase
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    out_item_t got, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.payload;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: %p", got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, got.ok); error_count++;
        end
        if (got.front_value !== want.front_value) begin
          $error("front_value: expected %0d, got %0d", want.front_value, got.front_value);
          error_count++;
        end
        if (got.back_value !== want.back_value) begin
          $error("back_value: expected %0d, got %0d", want.back_value, got.back_value);
          error_count++;
        end
        if (got.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
          error_count++;
        end
        if (got.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
          error_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no beat on either side. A full-list sort passes
  // no beat while it runs.
  always @(posedge clk_i) begin
    if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 250000) begin
      $display("linked_list_deque_engine_tb: errors");
      $finish;
    end
  end

  initial begin
    op_if.valid   = 1'b0;
    op_if.payload = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full();
    test_backpressure();
    test_random(1300);
    if (pending_results.size() != 0) error_count++;
    if (error_count == 0) $display("linked_list_deque_engine_tb: clean");
    else $display("linked_list_deque_engine_tb: errors");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/lldq_pkg.sv
rtl/core/lldq_stream_if.sv
rtl/core/lldq_ram.sv
rtl/core/lldq_dp.sv
rtl/core/lldq_ctrl.sv
rtl/core/linked_list_deque_engine.sv
tb/sv/linked_list_deque_engine_tb.sv
